FILE: rtl/sedge_pkg.sv
// sedge_pkg: constants, types and helpers of the sobel edge threshold block
// no dependencies
`timescale 1ns / 1ps

package sedge_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_DIM    = 3;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int FW_W       = 12;
    localparam int FH_W       = 13;
    localparam int PIX_W      = 8;
    localparam int GRAD_W     = 11;
    localparam int SQ_W       = 21;
    localparam int SUM_W      = SQ_W + 1;
    localparam int EDGE_LIMIT = 40000;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [PIX_W-1:0] PIX_EDGE = {PIX_W{1'b1}};
    localparam logic [PIX_W-1:0] PIX_FLAT = '0;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        rgb_t             pix;
        logic             last;
    } result_t;

    typedef struct packed {
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        rgb_t                     pix;
        logic                     has_int;
        logic                     has_bnd;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
    } grad_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        rgb_t             pix;
        logic             has_int;
        logic             has_bnd;
        logic [SQ_W-1:0]  gx2;
        logic [SQ_W-1:0]  gy2;
    } square_t;

    function automatic logic signed [GRAD_W:0] tap_ext(input logic [PIX_W-1:0] v);
        return $signed({{(GRAD_W + 1 - PIX_W){1'b0}}, v});
    endfunction

endpackage

FILE: rtl/sedge_if.sv
// sedge_if: pixel, result and configuration channels of the edge block
// depends on sedge_pkg
`timescale 1ns / 1ps

interface sedge_pix_if;
    logic                      valid;
    logic                      ready;
    logic [sedge_pkg::PIX_W-1:0] red_in;
    logic [sedge_pkg::PIX_W-1:0] green_in;
    logic [sedge_pkg::PIX_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface sedge_res_if;
    logic                        valid;
    logic                        ready;
    logic [sedge_pkg::ROW_W-1:0] out_row;
    logic [sedge_pkg::COL_W-1:0] out_col;
    logic [sedge_pkg::PIX_W-1:0] red_out;
    logic [sedge_pkg::PIX_W-1:0] green_out;
    logic [sedge_pkg::PIX_W-1:0] blue_out;
    logic                        last_of_run;

    modport source (output valid, output out_row, output out_col, output red_out,
                    output green_out, output blue_out, output last_of_run,
                    input ready);
    modport sink (input valid, input out_row, input out_col, input red_out,
                  input green_out, input blue_out, input last_of_run,
                  output ready);
endinterface

interface sedge_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [sedge_pkg::CFG_IDX_W-1:0]  wr_index;
    logic [sedge_pkg::CFG_DATA_W-1:0] wr_data;

    modport source (output valid, output wr_index, output wr_data, input ready);
    modport sink (input valid, input wr_index, input wr_data, output ready);
endinterface

FILE: rtl/sobel_edge_threshold.sv
// sobel_edge_threshold: streaming 3x3 sobel edge detector on the blue channel
// depends on sedge_pkg and the channel interfaces in sedge_if
`timescale 1ns / 1ps

// Pixels enter in raster order. Each pixel from row 2 and column 2 on yields
// the thresholded result of the interior pixel up and left of it and, on the
// border, its own passthrough result; every result carries its row and column.
// Results pass the gradient and square registers into an 8-entry queue drained
// at one beat per cycle while res.ready is high, so the input takes one pixel
// per cycle except on the last row and column, where such a pixel makes two
// results and, once the queue fills, the input is held back. The two 2048-entry
// line buffers are single-write, single-read memories with registered reads;
// the read for the next column is issued as the current pixel is taken. Line
// buffers are not cleared after reset and need no clearing pass. Width and
// height are clamped to 3..2048 and 3..4096; configuration is always ready.

module sobel_edge_threshold (
    input  logic        clk,
    input  logic        rst_n,
    sedge_pix_if.sink   pix,
    sedge_res_if.source res,
    sedge_cfg_if.sink   cfg
);

    // configuration
    logic [sedge_pkg::FW_W-1:0]  frame_width_reg;
    logic [sedge_pkg::FH_W-1:0]  frame_height_reg;
    logic [sedge_pkg::COL_W-1:0] col_last;
    logic [sedge_pkg::ROW_W-1:0] row_last;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= sedge_pkg::FW_W'(640);
            frame_height_reg <= sedge_pkg::FH_W'(480);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.wr_index)
                sedge_pkg::REG_FRAME_WIDTH:
                    frame_width_reg <= cfg.wr_data[sedge_pkg::FW_W-1:0];
                sedge_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= cfg.wr_data[sedge_pkg::FH_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        if (frame_width_reg < sedge_pkg::FW_W'(sedge_pkg::MIN_DIM))
            col_last = sedge_pkg::COL_W'(sedge_pkg::MIN_DIM - 1);
        else if (frame_width_reg > sedge_pkg::FW_W'(sedge_pkg::MAX_WIDTH))
            col_last = sedge_pkg::COL_W'(sedge_pkg::MAX_WIDTH - 1);
        else
            col_last = sedge_pkg::COL_W'(frame_width_reg - 1'b1);

        if (frame_height_reg < sedge_pkg::FH_W'(sedge_pkg::MIN_DIM))
            row_last = sedge_pkg::ROW_W'(sedge_pkg::MIN_DIM - 1);
        else if (frame_height_reg > sedge_pkg::FH_W'(sedge_pkg::MAX_HEIGHT))
            row_last = sedge_pkg::ROW_W'(sedge_pkg::MAX_HEIGHT - 1);
        else
            row_last = sedge_pkg::ROW_W'(frame_height_reg - 1'b1);
    end

    // position counters
    logic                        accept;
    logic [sedge_pkg::COL_W-1:0] col_reg;
    logic [sedge_pkg::COL_W-1:0] col_next;
    logic [sedge_pkg::ROW_W-1:0] row_reg;
    logic [sedge_pkg::ROW_W-1:0] row_next;
    logic                        at_last_col;
    logic                        at_last_row;

    assign accept      = pix.valid && pix.ready;
    assign at_last_col = col_reg >= col_last;
    assign at_last_row = row_reg >= row_last;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (at_last_col)
            begin
                col_next = '0;
                row_next = at_last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line buffers, read one column ahead
    logic [sedge_pkg::PIX_W-1:0] older_mem [sedge_pkg::MAX_WIDTH];
    logic [sedge_pkg::PIX_W-1:0] newer_mem [sedge_pkg::MAX_WIDTH];
    logic [sedge_pkg::PIX_W-1:0] top_reg;
    logic [sedge_pkg::PIX_W-1:0] mid_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            older_mem[col_reg] <= mid_reg;
            newer_mem[col_reg] <= pix.blue_in;
        end
        top_reg <= older_mem[col_next];
        mid_reg <= newer_mem[col_next];
    end

    // 3x3 window, two columns back
    logic [sedge_pkg::PIX_W-1:0] win_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (accept)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_reg;
            win_reg[4] <= mid_reg;
            win_reg[5] <= pix.blue_in;
        end
    end

    // gradient stage
    logic signed [sedge_pkg::GRAD_W:0] gx_full;
    logic signed [sedge_pkg::GRAD_W:0] gy_full;
    sedge_pkg::grad_t                  grad_next;
    sedge_pkg::grad_t                  grad_reg;
    logic                              grad_vld_reg;

    always_comb
    begin
        gx_full = sedge_pkg::tap_ext(top_reg) - sedge_pkg::tap_ext(win_reg[0])
                + ((sedge_pkg::tap_ext(mid_reg) - sedge_pkg::tap_ext(win_reg[1])) <<< 1)
                + sedge_pkg::tap_ext(pix.blue_in) - sedge_pkg::tap_ext(win_reg[2]);
        gy_full = sedge_pkg::tap_ext(pix.blue_in) + sedge_pkg::tap_ext(win_reg[2])
                + ((sedge_pkg::tap_ext(win_reg[5]) - sedge_pkg::tap_ext(win_reg[3])) <<< 1)
                - sedge_pkg::tap_ext(top_reg) - sedge_pkg::tap_ext(win_reg[0]);

        grad_next.row       = row_reg;
        grad_next.col       = col_reg;
        grad_next.pix.red   = pix.red_in;
        grad_next.pix.green = pix.green_in;
        grad_next.pix.blue  = pix.blue_in;
        grad_next.has_int   = (row_reg >= sedge_pkg::ROW_W'(2))
                           && (col_reg >= sedge_pkg::COL_W'(2));
        grad_next.has_bnd   = (row_reg == '0) || at_last_row
                           || (col_reg == '0) || at_last_col;
        grad_next.gx        = gx_full[sedge_pkg::GRAD_W-1:0];
        grad_next.gy        = gy_full[sedge_pkg::GRAD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            grad_reg <= grad_next;
    end

    // square stage
    logic signed [2*sedge_pkg::GRAD_W-1:0] gx_prod;
    logic signed [2*sedge_pkg::GRAD_W-1:0] gy_prod;
    sedge_pkg::square_t                    sq_reg;
    logic                                  sq_vld_reg;

    assign gx_prod = grad_reg.gx * grad_reg.gx;
    assign gy_prod = grad_reg.gy * grad_reg.gy;

    always_ff @(posedge clk)
    begin
        if (grad_vld_reg)
        begin
            sq_reg.row     <= grad_reg.row;
            sq_reg.col     <= grad_reg.col;
            sq_reg.pix     <= grad_reg.pix;
            sq_reg.has_int <= grad_reg.has_int;
            sq_reg.has_bnd <= grad_reg.has_bnd;
            sq_reg.gx2     <= gx_prod[sedge_pkg::SQ_W-1:0];
            sq_reg.gy2     <= gy_prod[sedge_pkg::SQ_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grad_vld_reg <= 1'b0;
            sq_vld_reg   <= 1'b0;
        end
        else
        begin
            grad_vld_reg <= accept;
            sq_vld_reg   <= grad_vld_reg;
        end
    end

    // threshold and result queue
    logic [sedge_pkg::SUM_W-1:0]      mag;
    logic [sedge_pkg::PIX_W-1:0]      edge_val;
    sedge_pkg::result_t               int_res;
    sedge_pkg::result_t               bnd_res;
    sedge_pkg::result_t               first_res;
    logic [1:0]                       push_n;
    logic [1:0]                       grad_n;
    logic                             pop;
    logic [sedge_pkg::FIFO_CNT_W:0]   outstanding;

    sedge_pkg::result_t               fifo_mem [sedge_pkg::FIFO_DEPTH];
    logic [sedge_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [sedge_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [sedge_pkg::FIFO_CNT_W-1:0] count_reg;

    always_comb
    begin
        mag      = {1'b0, sq_reg.gx2} + {1'b0, sq_reg.gy2};
        edge_val = (mag > sedge_pkg::SUM_W'(sedge_pkg::EDGE_LIMIT))
                 ? sedge_pkg::PIX_EDGE : sedge_pkg::PIX_FLAT;

        int_res.row       = sq_reg.row - 1'b1;
        int_res.col       = sq_reg.col - 1'b1;
        int_res.pix.red   = edge_val;
        int_res.pix.green = edge_val;
        int_res.pix.blue  = edge_val;
        int_res.last      = !sq_reg.has_bnd;

        bnd_res.row  = sq_reg.row;
        bnd_res.col  = sq_reg.col;
        bnd_res.pix  = sq_reg.pix;
        bnd_res.last = 1'b1;

        first_res = sq_reg.has_int ? int_res : bnd_res;

        push_n = sq_vld_reg ? {1'b0, sq_reg.has_int} + {1'b0, sq_reg.has_bnd} : 2'd0;
        grad_n = grad_vld_reg ? {1'b0, grad_reg.has_int} + {1'b0, grad_reg.has_bnd}
                              : 2'd0;
        pop    = res.valid && res.ready;

        outstanding = {1'b0, count_reg} + (sedge_pkg::FIFO_CNT_W + 1)'(push_n)
                    + (sedge_pkg::FIFO_CNT_W + 1)'(grad_n);
    end

    assign pix.ready = outstanding <= (sedge_pkg::FIFO_CNT_W + 1)'(sedge_pkg::FIFO_DEPTH - 2);

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            fifo_mem[wr_ptr_reg] <= first_res;
        if (push_n == 2'd2)
            fifo_mem[wr_ptr_reg + 1'b1] <= bnd_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + sedge_pkg::FIFO_PTR_W'(push_n);
            rd_ptr_reg <= rd_ptr_reg + sedge_pkg::FIFO_PTR_W'(pop);
            count_reg  <= count_reg + sedge_pkg::FIFO_CNT_W'(push_n)
                        - sedge_pkg::FIFO_CNT_W'(pop);
        end
    end

    // result beat
    sedge_pkg::result_t head;

    assign head            = fifo_mem[rd_ptr_reg];
    assign res.valid       = count_reg != '0;
    assign res.out_row     = head.row;
    assign res.out_col     = head.col;
    assign res.red_out     = head.pix.red;
    assign res.green_out   = head.pix.green;
    assign res.blue_out    = head.pix.blue;
    assign res.last_of_run = head.last;

    // checks
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sedge_pkg::FIFO_CNT_W'(sedge_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !at_last_col |=> col_reg == $past(col_reg) + 1'b1)
        else $error("column counter did not step");

    a_pair_queued: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.last_of_run |-> count_reg >= sedge_pkg::FIFO_CNT_W'(2))
        else $error("first result of a pair without its partner");

    a_wrap_row: assert property (@(posedge clk) disable iff (!rst_n)
        accept && at_last_col && at_last_row |=> row_reg == '0 && col_reg == '0)
        else $error("frame end did not wrap");

endmodule

FILE: test/sobel_edge_threshold_test.sv
// sobel_edge_threshold_test: self-checking bench for the sobel edge threshold block,
// predicts every result beat from its own line-buffer and window copy of the block state
// depends on sedge_pkg, the channel interfaces in sedge_if and sobel_edge_threshold
`timescale 1ns / 1ps

module sobel_edge_threshold_test;

    localparam int HALF_PERIOD   = 6;
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_LIMIT   = 200000;
    localparam int MAX_GAP       = 60;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [sedge_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = sedge_pkg::CFG_IDX_W'(2);
    localparam logic [sedge_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = sedge_pkg::CFG_IDX_W'(3);

    typedef enum int {PAT_NOISE, PAT_FLAT, PAT_STEP, PAT_DIAG, PAT_RAILS} pattern_t;

    logic clk;
    logic rst_n;

    sedge_pix_if pix_ch ();
    sedge_res_if res_ch ();
    sedge_cfg_if cfg_ch ();

    sobel_edge_threshold i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // predicted block state
    logic [sedge_pkg::FW_W-1:0]  width_reg;
    logic [sedge_pkg::FH_W-1:0]  height_reg;
    logic [sedge_pkg::PIX_W-1:0] older_blue [sedge_pkg::MAX_WIDTH];
    logic [sedge_pkg::PIX_W-1:0] newer_blue [sedge_pkg::MAX_WIDTH];
    logic [sedge_pkg::PIX_W-1:0] win_blue [6];
    int                          row_pos;
    int                          col_pos;

    sedge_pkg::result_t queued_out_px [$];

    int pix_idle_pct;
    int res_stall_pct;
    int error_count;
    int pixels_sent;
    int beats_checked;
    int frames_sent;

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_ch.ready = ($urandom_range(99) >= res_stall_pct);
        end
    end

    initial
    begin
        #20_000_000;
        $display("sobel_edge_threshold test failed");
        $finish;
    end

    function automatic int clamp_dim(input int v, input int hi);
        if (v < sedge_pkg::MIN_DIM)
            return sedge_pkg::MIN_DIM;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void log_error(input string msg);
        if (error_count < REPORT_LIMIT)
            $display("%s", msg);
        error_count++;
    endfunction

    // one pixel through the window: interior result of the pixel up-left, then border passthrough
    function automatic void sobel_step(input sedge_pkg::rgb_t p);
        int                          w, h, idx, n;
        int                          nw, wv, sw, nn, ss, ne, ee, se, gx, gy;
        logic [sedge_pkg::PIX_W-1:0] top, mid, v;
        logic                        last_col, last_row;
        sedge_pkg::result_t          r;
        w = clamp_dim(width_reg, sedge_pkg::MAX_WIDTH);
        h = clamp_dim(height_reg, sedge_pkg::MAX_HEIGHT);
        idx = col_pos % sedge_pkg::MAX_WIDTH;
        top = older_blue[idx];
        mid = newer_blue[idx];
        last_col = (col_pos >= w - 1);
        last_row = (row_pos >= h - 1);
        n = 0;
        if (row_pos >= 2 && col_pos >= 2)
        begin
            nw = win_blue[0];
            wv = win_blue[1];
            sw = win_blue[2];
            nn = win_blue[3];
            ss = win_blue[5];
            ne = top;
            ee = mid;
            se = p.blue;
            gx = -nw + ne - 2 * wv + 2 * ee - sw + se;
            gy = se + 2 * ss + sw - ne - 2 * nn - nw;
            v = (gx * gx + gy * gy > sedge_pkg::EDGE_LIMIT) ? sedge_pkg::PIX_EDGE
                                                           : sedge_pkg::PIX_FLAT;
            r.row = sedge_pkg::ROW_W'(row_pos - 1);
            r.col = sedge_pkg::COL_W'(col_pos - 1);
            r.pix = '{red: v, green: v, blue: v};
            r.last = 1'b0;
            queued_out_px.push_back(r);
            n++;
        end
        if (row_pos == 0 || last_row || col_pos == 0 || last_col)
        begin
            r.row = sedge_pkg::ROW_W'(row_pos);
            r.col = sedge_pkg::COL_W'(col_pos);
            r.pix = p;
            r.last = 1'b0;
            queued_out_px.push_back(r);
            n++;
        end
        if (n > 0)
            queued_out_px[queued_out_px.size() - 1].last = 1'b1;

        win_blue[0] = win_blue[3];
        win_blue[1] = win_blue[4];
        win_blue[2] = win_blue[5];
        win_blue[3] = top;
        win_blue[4] = mid;
        win_blue[5] = p.blue;
        older_blue[idx] = mid;
        newer_blue[idx] = p.blue;

        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = col_pos + 1;
        end
    endfunction

    function automatic sedge_pkg::rgb_t make_pixel(input pattern_t pat, input int row,
                                                   input int col, input int split_col,
                                                   input logic [sedge_pkg::PIX_W-1:0] lo,
                                                   input logic [sedge_pkg::PIX_W-1:0] hi);
        sedge_pkg::rgb_t p;
        p.red = sedge_pkg::PIX_W'($urandom_range(255));
        p.green = sedge_pkg::PIX_W'($urandom_range(255));
        case (pat)
            PAT_NOISE: p.blue = sedge_pkg::PIX_W'($urandom_range(255));
            PAT_FLAT:  p.blue = lo + sedge_pkg::PIX_W'($urandom_range(3));
            PAT_STEP:  p.blue = (col >= split_col) ? hi : lo;
            PAT_DIAG:  p.blue = (row + col >= split_col) ? hi : lo;
            default:
            begin
                p.red = $urandom_range(1) ? '1 : '0;
                p.green = $urandom_range(1) ? '1 : '0;
                p.blue = $urandom_range(1) ? '1 : '0;
            end
        endcase
        return p;
    endfunction

    function automatic int random_dim();
        if ($urandom_range(9) == 0)
            return $urandom_range(2);
        if ($urandom_range(7) == 0)
            return $urandom_range(40, 3);
        return $urandom_range(10, 3);
    endfunction

    task automatic send_pixel(input sedge_pkg::rgb_t p);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < pix_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            pix_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_ch.valid = 1'b1;
        pix_ch.red_in = p.red;
        pix_ch.green_in = p.green;
        pix_ch.blue_in = p.blue;
        do
            @(posedge clk);
        while (pix_ch.ready !== 1'b1);
        sobel_step(p);
        pixels_sent++;
    endtask

    task automatic stop_pixels();
        @(negedge clk);
        pix_ch.valid = 1'b0;
    endtask

    task automatic write_reg(input logic [sedge_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sedge_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.wr_index = idx;
        cfg_ch.wr_data = data;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        if (idx == sedge_pkg::REG_FRAME_WIDTH)
            width_reg = data[sedge_pkg::FW_W-1:0];
        else if (idx == sedge_pkg::REG_FRAME_HEIGHT)
            height_reg = data[sedge_pkg::FH_W-1:0];
    endtask

    // frame size changes only with the pipeline empty
    task automatic set_frame(input int w, input int h);
        stop_pixels();
        while (queued_out_px.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if ($urandom_range(7) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO,
                      sedge_pkg::CFG_DATA_W'($urandom_range(8191)));
        write_reg(sedge_pkg::REG_FRAME_WIDTH, sedge_pkg::CFG_DATA_W'(w));
        write_reg(sedge_pkg::REG_FRAME_HEIGHT, sedge_pkg::CFG_DATA_W'(h));
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic send_frame();
        int                          w, h, split_col;
        pattern_t                    pat;
        logic [sedge_pkg::PIX_W-1:0] lo, hi;
        w = clamp_dim(width_reg, sedge_pkg::MAX_WIDTH);
        h = clamp_dim(height_reg, sedge_pkg::MAX_HEIGHT);
        pat = pattern_t'($urandom_range(PAT_RAILS));
        split_col = $urandom_range(w - 1);
        lo = sedge_pkg::PIX_W'($urandom_range(255));
        hi = sedge_pkg::PIX_W'($urandom_range(255));
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                send_pixel(make_pixel(pat, r, c, split_col, lo, hi));
        frames_sent++;
    endtask

    // 3x3 frames: gradient exactly at the threshold, just above it, and full-scale rails
    task automatic test_directed_windows();
        int blues [3][9] = '{'{0, 10, 50, 0, 77, 50, 0, 10, 50},
                             '{0, 10, 51, 0, 77, 50, 0, 10, 51},
                             '{0, 0, 255, 0, 0, 255, 255, 255, 255}};
        pix_idle_pct = 0;
        res_stall_pct = 0;
        set_frame(0, 2);
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 9; i++)
                send_pixel('{red: ((i + k) % 2) ? 8'hFF : 8'h00,
                             green: ((i + k) % 2) ? 8'h00 : 8'hFF,
                             blue: sedge_pkg::PIX_W'(blues[k][i])});
            frames_sent++;
        end
    endtask

    // low clamps of width and height
    task automatic test_dimension_extremes();
        pix_idle_pct = 0;
        res_stall_pct = 0;
        set_frame(1, 0);
        send_frame();
        set_frame(2, 1);
        send_frame();
        set_frame(7, 2);
        send_frame();
    endtask

    task automatic test_random_frames(input int idle_pct, input int stall_pct,
                                      input int pixel_goal);
        int start;
        pix_idle_pct = idle_pct;
        res_stall_pct = stall_pct;
        start = pixels_sent;
        while (pixels_sent - start < pixel_goal)
        begin
            if ($urandom_range(1))
                set_frame(random_dim(), random_dim());
            send_frame();
        end
    endtask

    always @(posedge clk)
    begin
        sedge_pkg::result_t got;
        sedge_pkg::result_t want;
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            got.row = res_ch.out_row;
            got.col = res_ch.out_col;
            got.pix = '{red: res_ch.red_out, green: res_ch.green_out, blue: res_ch.blue_out};
            got.last = res_ch.last_of_run;
            if (queued_out_px.size() == 0)
            begin
                log_error($sformatf("unexpected beat at %0t: row %0d col %0d rgb %0d/%0d/%0d",
                                    $realtime, got.row, got.col, got.pix.red, got.pix.green,
                                    got.pix.blue));
            end
            else
            begin
                want = queued_out_px.pop_front();
                if (got.row !== want.row || got.col !== want.col
                    || got.pix.red !== want.pix.red || got.pix.green !== want.pix.green
                    || got.pix.blue !== want.pix.blue || got.last !== want.last)
                    log_error($sformatf({"mismatch at %0t: expected row %0d col %0d ",
                                         "rgb %0d/%0d/%0d last %0d, got row %0d col %0d ",
                                         "rgb %0d/%0d/%0d last %0d"},
                                        $realtime, want.row, want.col, want.pix.red,
                                        want.pix.green, want.pix.blue, want.last, got.row,
                                        got.col, got.pix.red, got.pix.green, got.pix.blue,
                                        got.last));
            end
            beats_checked++;
        end
    end

    initial
    begin
        int drain_wait;
        rst_n = 1'b0;
        pix_ch.valid = 1'b0;
        pix_ch.red_in = '0;
        pix_ch.green_in = '0;
        pix_ch.blue_in = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.wr_index = sedge_pkg::REG_FRAME_WIDTH;
        cfg_ch.wr_data = '0;
        width_reg = sedge_pkg::FW_W'(640);
        height_reg = sedge_pkg::FH_W'(480);
        foreach (older_blue[i])
        begin
            older_blue[i] = '0;
            newer_blue[i] = '0;
        end
        foreach (win_blue[i])
            win_blue[i] = '0;
        row_pos = 0;
        col_pos = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_windows();
        test_dimension_extremes();
        test_random_frames(0, 0, 350);
        test_random_frames(86, 0, 350);
        test_random_frames(0, 86, 350);
        test_random_frames(32, 32, 350);

        stop_pixels();
        drain_wait = 0;
        while (queued_out_px.size() != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (queued_out_px.size() != 0)
            log_error($sformatf("%0d result beats never arrived", queued_out_px.size()));

        $display("run: %0d pixels in %0d frames, %0d result beats checked, %0d errors",
                 pixels_sent, frames_sent, beats_checked, error_count);
        $display("run: threshold windows, low size clamps, random frames to 40x40, idle and stall");
        if (error_count == 0)
            $display("sobel_edge_threshold test passed");
        else
            $display("sobel_edge_threshold test failed");
        $finish;
    end

endmodule
